// ===== design/cht_pkg.sv =====
package cht_pkg;

  localparam int Buckets = 1024;
  localparam int Records = 1024;
  localparam int BW = $clog2(Buckets);
  localparam int NW = $clog2(Records);
  localparam int PW = NW + 1;
  localparam logic [PW-1:0] NIL = '1;
  localparam logic [10:0] PROBE_MAX = 11'd2047;
  localparam logic [23:0] SUM_MAX = 24'hFFFFFF;
  localparam logic [15:0] TALLY_MAX = 16'hFFFF;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [6:0] name_char;
    logic       last_char;
    logic [9:0] record_index;
  } req_t;

  typedef struct packed {
    logic [9:0]  bucket;
    logic [10:0] probe_count;
    logic [1:0]  status;
    logic [23:0] probe_total;
    logic [15:0] lookups_done;
  } rsp_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_READ_BKT, OP_INS_HEAD, OP_INS_FULL, OP_INS_NODE,
    OP_INS_START, OP_READ_NODE, OP_STEP, OP_LINK, OP_FOUND_HEAD,
    OP_FOUND_NODE, OP_MISS, OP_CLEAR
  } op_t;

  typedef struct packed {
    logic head_valid;
    logic head_match;
    logic start_nil;
    logic pool_full;
    logic link_nil;
    logic node_match;
    logic ptr_nil;
    logic steps_done;
    logic req_lookup;
    logic clear_last;
  } stat_t;

  function automatic logic [31:0] fold_char(input logic [31:0] h, input logic [6:0] c);
    logic [31:0] t;
    logic [31:0] top;
    t = (h << 4) + {25'd0, c};
    top = t & 32'hF0000000;
    if (top != 32'd0) begin
      t = (t ^ (top >> 24)) & ~top;
    end
    return t;
  endfunction

endpackage

// ===== design/cht_ctrl.sv =====
module cht_ctrl import cht_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  logic  last_char,
  input  stat_t stat,
  output logic  busy,
  output op_t   op
);

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_BKT, S_DECIDE, S_NODE, S_WALK} state_t;
  state_t state;

  always_comb begin
    op = OP_NONE;
    unique case (state)
      S_CLEAR: op = OP_CLEAR;
      S_IDLE: if (start && last_char) op = OP_LOAD;
      S_BKT: op = OP_READ_BKT;
      S_DECIDE: begin
        if (!stat.req_lookup) begin
          if (!stat.head_valid) op = OP_INS_HEAD;
          else if (stat.pool_full) op = OP_INS_FULL;
          else if (stat.start_nil) op = OP_INS_START;
          else op = OP_INS_NODE;
        end else if (stat.head_valid && stat.head_match) op = OP_FOUND_HEAD;
        else if (stat.ptr_nil) op = OP_MISS;
        else op = OP_INS_NODE;
      end
      S_NODE: op = OP_READ_NODE;
      S_WALK: begin
        if (!stat.req_lookup) begin
          if (stat.link_nil || stat.steps_done) op = OP_LINK;
          else op = OP_STEP;
        end else if (stat.node_match) op = OP_FOUND_NODE;
        else if (stat.link_nil || stat.steps_done) op = OP_MISS;
        else op = OP_STEP;
      end
      default: op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      busy <= 1'b1;
    end else begin
      unique case (op)
        OP_CLEAR: begin
          if (stat.clear_last) begin
            state <= S_IDLE;
            busy <= 1'b0;
          end
        end
        OP_LOAD: begin state <= S_BKT; busy <= 1'b1; end
        OP_READ_BKT: state <= S_DECIDE;
        OP_INS_NODE, OP_STEP: state <= S_NODE;
        OP_READ_NODE: state <= S_WALK;
        OP_INS_HEAD, OP_INS_FULL, OP_INS_START, OP_LINK, OP_FOUND_HEAD,
        OP_FOUND_NODE, OP_MISS: begin state <= S_IDLE; busy <= 1'b0; end
        default: ;
      endcase
    end
  end

endmodule

// ===== design/cht_dp.sv =====
module cht_dp import cht_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  logic  busy,
  input  req_t  req,
  input  op_t   op,
  output stat_t stat,
  output logic  done,
  output rsp_t  rsp
);

  logic [31:0]   hash;
  logic [BW-1:0] bkt;
  logic          rtype;
  logic [9:0]    rec;
  logic [BW-1:0] clr;
  logic [PW-1:0] head_mem [Buckets];
  logic [PW-1:0] start_mem [Buckets];
  logic [9:0]    nrec_mem [Records];
  logic [PW-1:0] nlink_mem [Records];
  logic [PW-1:0] head_q;
  logic [PW-1:0] start_q;
  logic [9:0]    nrec_q;
  logic [PW-1:0] nlink_q;
  logic [PW-1:0] ptr;
  logic [NW:0]   used;
  logic [NW:0]   steps;
  logic [10:0]   probe;
  logic [23:0]   psum;
  logic [15:0]   tally;
  logic [31:0]   hash_next;
  logic [10:0]   probe_inc;
  logic [23:0]   psum_p;
  logic [15:0]   tally_p;

  assign hash_next = fold_char(hash, req.name_char);
  assign probe_inc = (probe < PROBE_MAX) ? probe + 11'd1 : PROBE_MAX;
  assign psum_p = ((SUM_MAX - psum) < {13'd0, probe}) ? SUM_MAX : psum + {13'd0, probe};
  assign tally_p = (tally < TALLY_MAX) ? tally + 16'd1 : tally;

  assign stat.head_valid = head_q != NIL;
  assign stat.head_match = head_q == {1'b0, rec};
  assign stat.start_nil = start_q == NIL;
  assign stat.pool_full = used >= (NW+1)'(Records);
  assign stat.link_nil = nlink_q == NIL;
  assign stat.node_match = nrec_q == rec;
  assign stat.ptr_nil = start_q == NIL;
  assign stat.steps_done = steps >= (NW+1)'(Records);
  assign stat.req_lookup = rtype == REQ_LOOKUP;
  assign stat.clear_last = clr == BW'(Buckets - 1);

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      hash <= req.last_char ? 32'd0 : hash_next;
      if (req.last_char) begin
        bkt <= BW'((hash_next & 32'h7FFFFFFF) % Buckets);
        rtype <= req.req_type;
        rec <= req.record_index;
      end
    end
    head_q <= head_mem[bkt];
    start_q <= start_mem[bkt];
    nrec_q <= nrec_mem[ptr[NW-1:0]];
    nlink_q <= nlink_mem[ptr[NW-1:0]];
    done <= 1'b0;
    unique case (op)
      OP_CLEAR: begin
        head_mem[clr] <= NIL;
        start_mem[clr] <= NIL;
        clr <= clr + 1'b1;
      end
      OP_READ_BKT: steps <= '0;
      OP_INS_HEAD: begin
        head_mem[bkt] <= {1'b0, rec};
        done <= 1'b1;
        rsp <= '{bkt, 11'd1, ST_OK, psum, tally};
      end
      OP_INS_FULL: begin
        done <= 1'b1;
        rsp <= '{bkt, 11'd0, ST_FULL, psum, tally};
      end
      OP_INS_START: begin
        start_mem[bkt] <= {1'b0, used[NW-1:0]};
        nrec_mem[used[NW-1:0]] <= rec;
        nlink_mem[used[NW-1:0]] <= NIL;
        used <= used + 1'b1;
        done <= 1'b1;
        rsp <= '{bkt, 11'd2, ST_OK, psum, tally};
      end
      OP_INS_NODE: begin
        ptr <= start_q;
        probe <= 11'd2;
        // new node is filled now, linked in at the chain tail
        if (rtype == REQ_INSERT) begin
          nrec_mem[used[NW-1:0]] <= rec;
          nlink_mem[used[NW-1:0]] <= NIL;
        end
      end
      OP_STEP: begin
        ptr <= nlink_q;
        probe <= probe_inc;
        steps <= steps + 1'b1;
      end
      OP_LINK: begin
        nlink_mem[ptr[NW-1:0]] <= {1'b0, used[NW-1:0]};
        used <= used + 1'b1;
        done <= 1'b1;
        rsp <= '{bkt, probe_inc, ST_OK, psum, tally};
      end
      OP_FOUND_HEAD: begin
        done <= 1'b1;
        rsp <= '{bkt, 11'd1, ST_OK, (SUM_MAX - psum < 24'd1) ? SUM_MAX : psum + 24'd1,
                 (tally < TALLY_MAX) ? tally + 16'd1 : tally};
        psum <= (SUM_MAX - psum < 24'd1) ? SUM_MAX : psum + 24'd1;
        if (tally < TALLY_MAX) tally <= tally + 16'd1;
      end
      OP_FOUND_NODE: begin
        done <= 1'b1;
        rsp <= '{bkt, probe, ST_OK, psum_p, tally_p};
        psum <= psum_p;
        tally <= tally_p;
      end
      OP_MISS: begin
        done <= 1'b1;
        rsp <= '{bkt, 11'd0, ST_MISS, psum, tally};
      end
      default: ;
    endcase
    if (rst) begin
      hash <= '0;
      clr <= '0;
      used <= '0;
      psum <= '0;
      tally <= '0;
      done <= 1'b0;
    end
  end

endmodule

// ===== design/chained_string_hash_table.sv =====
// a plain character is taken while idle; a last character keeps busy high through the bucket read
// and the decide step, then through a node read and compare for each chain node visited
// the result is registered onto done by the decide or compare step that ends the request
// one character per cycle while idle; results appear for one cycle on done,
// the receiver cannot stall
// synchronous active-high reset clears counters, then busy stays high while the clear state empties every bucket
module chained_string_hash_table import cht_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  req_t req,
  output logic busy,
  output logic done,
  output rsp_t rsp
);

  stat_t stat;
  op_t   op;

  cht_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .last_char(req.last_char),
    .stat(stat), .busy(busy), .op(op)
  );

  cht_dp u_dp (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req), .op(op),
    .stat(stat), .done(done), .rsp(rsp)
  );

endmodule
